// File: src/refcounted_lru_handle_cache_defines.svh
// Assertion macros shared by the handle cache RTL.
`ifndef REFCOUNTED_LRU_HANDLE_CACHE_DEFINES_SVH
`define REFCOUNTED_LRU_HANDLE_CACHE_DEFINES_SVH
`ifndef SYNTH
`define RLHC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("handle cache assertion failed");
`define RLHC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("handle cache assertion failed");
`else
`define RLHC_ASSERT(lbl, clk, rst_n, prop)
`define RLHC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/rlhc_pkg.sv
// ----------------------------------------------------------------------------
// rlhc_pkg
// Types, codes and sizes of the reference-counted handle cache.
// ----------------------------------------------------------------------------
package rlhc_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int REF_BITS = 16;

    localparam logic [1:0] CMD_GET    = 2'd0;
    localparam logic [1:0] CMD_PUT    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [3:0] STS_HIT         = 4'd0;
    localparam logic [3:0] STS_FILL_FREE   = 4'd1;
    localparam logic [3:0] STS_FILL_EVICT  = 4'd2;
    localparam logic [3:0] STS_BYPASS      = 4'd3;
    localparam logic [3:0] STS_PUT_KEPT    = 4'd4;
    localparam logic [3:0] STS_PUT_RELEASE = 4'd5;
    localparam logic [3:0] STS_PUT_UNCACHE = 4'd6;
    localparam logic [3:0] STS_REMOVED     = 4'd7;
    localparam logic [3:0] STS_NOT_CACHED  = 4'd8;
    localparam logic [3:0] STS_IN_USE      = 4'd9;
    localparam logic [3:0] STS_COUNT_ERR   = 4'd10;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] key_collection;
        logic [63:0]        key_handle;
        logic [1:0]         open_kind;
        logic               ref_cached;
        logic [5:0]         ref_slot;
    } t_in;

    typedef struct packed {
        logic [3:0]         status;
        logic [5:0]         slot;
        logic               need_open;
        logic               need_close;
        logic signed [31:0] close_collection;
        logic [63:0]        close_handle;
        logic [1:0]         close_kind;
    } t_out;

    typedef struct packed {
        logic signed [31:0] coll;
        logic [63:0]        handle;
        logic [1:0]         okind;
    } t_key;

    typedef struct packed {
        logic                unused;
        logic [REF_BITS-1:0] refs;
    } t_meta;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MRD,
        S_DECIDE,
        S_MISS,
        S_POP,
        S_LRD,
        S_UNLINK,
        S_FILL,
        S_OUT
    } t_state;

endpackage

// File: src/refcounted_lru_handle_cache.sv
// ----------------------------------------------------------------------------
// refcounted_lru_handle_cache
// 64-entry cache of (collection, handle) keys with reference counts, a free
// stack and an unused queue kept in order of release.
// ----------------------------------------------------------------------------
// One request is handled at a time, and the input stalls from the accepting
// edge until the result word is loaded. A cached put passes through S_MRD,
// S_DECIDE and S_OUT; an uncached put or an unknown command goes straight to
// S_OUT. A get or a remove scans the key memory, one entry per cycle through
// its single read port, until a match or the last entry, and any update of
// the tables follows the scan. While the output holds a word that the
// receiver stalls, a finished request waits in its last state. No clearing
// pass is needed after reset.
module refcounted_lru_handle_cache
    import rlhc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

`include "refcounted_lru_handle_cache_defines.svh"

    // Memories
    t_key              key_mem  [ENTRIES];
    t_meta             meta_mem [ENTRIES];
    logic [IDX_W-1:0]  next_mem [ENTRIES];
    logic [IDX_W-1:0]  prev_mem [ENTRIES];
    logic [IDX_W-1:0]  stk_mem  [ENTRIES];

    t_key             r_key_rd;
    t_meta            r_meta_rd;
    logic [IDX_W-1:0] r_next_rd, r_prev_rd, r_stk_rd;

    logic [IDX_W-1:0] key_raddr, meta_raddr, link_raddr, stk_raddr;
    logic             key_we, meta_we, next_we, prev_we, stk_we;
    logic [IDX_W-1:0] key_waddr, meta_waddr, next_waddr, prev_waddr, stk_waddr;
    t_key             key_wdata;
    t_meta            meta_wdata;
    logic [IDX_W-1:0] next_wdata, prev_wdata, stk_wdata;

    // Control and working registers
    t_state             r_state, n_state;
    t_in                r_req, n_req;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic [IDX_W-1:0]   r_e, n_e;
    logic [IDX_W-1:0]   r_sidx, n_sidx;
    logic               r_fill, n_fill;
    t_key               r_close, n_close;
    t_out               r_res, n_res;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [ENTRIES-1:0] r_live, n_live;
    logic [ENTRIES-1:0] r_stk_wr, n_stk_wr;
    logic [CNT_W-1:0]   r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]   r_qcnt, n_qcnt;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;

    logic accept;
    logic key_match;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign key_match = r_pend && r_live[r_pidx] &&
                       (r_key_rd.coll == r_req.key_collection) &&
                       (r_key_rd.handle == r_req.key_handle);

    always_ff @(posedge i_clk) begin
        if (key_we)  key_mem[key_waddr]   <= key_wdata;
        if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
        if (next_we) next_mem[next_waddr] <= next_wdata;
        if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
        if (stk_we)  stk_mem[stk_waddr]   <= stk_wdata;
        r_key_rd  <= key_mem[key_raddr];
        r_meta_rd <= meta_mem[meta_raddr];
        r_next_rd <= next_mem[link_raddr];
        r_prev_rd <= prev_mem[link_raddr];
        r_stk_rd  <= stk_mem[stk_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_e         = r_e;
        n_sidx      = r_sidx;
        n_fill      = r_fill;
        n_close     = r_close;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_live      = r_live;
        n_stk_wr    = r_stk_wr;
        n_free_cnt  = r_free_cnt;
        n_qcnt      = r_qcnt;
        n_head      = r_head;
        n_tail      = r_tail;

        key_raddr  = r_idx[IDX_W-1:0];
        meta_raddr = r_e;
        link_raddr = r_e;
        stk_raddr  = r_sidx;
        key_we     = 1'b0;
        meta_we    = 1'b0;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        stk_we     = 1'b0;
        key_waddr  = r_e;
        meta_waddr = r_e;
        next_waddr = r_e;
        prev_waddr = r_e;
        stk_waddr  = r_free_cnt[IDX_W-1:0];
        key_wdata  = '{coll: r_req.key_collection, handle: r_req.key_handle,
                       okind: r_req.open_kind};
        meta_wdata = '{unused: 1'b0, refs: REF_BITS'(1)};
        next_wdata = r_e;
        prev_wdata = r_e;
        stk_wdata  = r_e;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req  = i_in;
                    n_res  = '0;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_fill = 1'b0;
                    n_e    = i_in.ref_slot;
                    priority if (i_in.command == CMD_GET ||
                                 i_in.command == CMD_REMOVE) begin
                        n_state = S_SCAN;
                    end else if (i_in.command == CMD_PUT) begin
                        if (i_in.ref_cached) begin
                            n_state = S_MRD;
                        end else begin
                            n_res.status     = STS_PUT_UNCACHE;
                            n_res.need_close = 1'b1;
                            n_state          = S_OUT;
                        end
                    end else begin
                        n_res.status = STS_COUNT_ERR;
                        n_state      = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                // Read of entry r_idx issued now; its data is compared next cycle.
                n_pend = (r_idx < CNT_W'(ENTRIES));
                n_pidx = r_idx[IDX_W-1:0];
                n_idx  = r_idx + CNT_W'(1);
                if (key_match) begin
                    n_e     = r_pidx;
                    n_close = r_key_rd;
                    n_state = S_MRD;
                end else if (r_pend && r_pidx == IDX_W'(ENTRIES - 1)) begin
                    if (r_req.command == CMD_GET) begin
                        n_state = S_MISS;
                    end else begin
                        n_res.status = STS_NOT_CACHED;
                        n_state      = S_OUT;
                    end
                end
            end
            S_MRD: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res.slot = r_e;
                n_state    = S_OUT;
                unique case (r_req.command)
                    CMD_GET: begin
                        if (&r_meta_rd.refs) begin
                            n_res.status = STS_COUNT_ERR;
                        end else begin
                            n_res.status = STS_HIT;
                            meta_we      = 1'b1;
                            meta_wdata   = '{unused: 1'b0,
                                             refs: r_meta_rd.refs + REF_BITS'(1)};
                            if (r_meta_rd.unused) n_state = S_LRD;
                        end
                    end
                    CMD_PUT: begin
                        if (!r_live[r_e] || r_meta_rd.unused || r_meta_rd.refs == '0) begin
                            n_res.status = STS_COUNT_ERR;
                        end else begin
                            meta_we    = 1'b1;
                            meta_wdata = '{unused: (r_meta_rd.refs == REF_BITS'(1)),
                                           refs: r_meta_rd.refs - REF_BITS'(1)};
                            if (r_meta_rd.refs == REF_BITS'(1)) begin
                                // Released entry joins the tail of the unused queue.
                                n_res.status = STS_PUT_RELEASE;
                                if (r_qcnt == '0) begin
                                    n_head = r_e;
                                end else begin
                                    next_we    = 1'b1;
                                    next_waddr = r_tail;
                                    prev_we    = 1'b1;
                                    prev_wdata = r_tail;
                                end
                                n_tail = r_e;
                                n_qcnt = r_qcnt + CNT_W'(1);
                            end else begin
                                n_res.status = STS_PUT_KEPT;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_meta_rd.unused) begin
                            n_res.status = STS_IN_USE;
                        end else begin
                            n_res.status           = STS_REMOVED;
                            n_res.need_close       = 1'b1;
                            n_res.close_collection = r_close.coll;
                            n_res.close_handle     = r_close.handle;
                            n_res.close_kind       = r_close.okind;
                            n_live[r_e]            = 1'b0;
                            if (r_free_cnt < CNT_W'(ENTRIES)) begin
                                stk_we                                  = 1'b1;
                                n_stk_wr[r_free_cnt[IDX_W-1:0]]         = 1'b1;
                                n_free_cnt                              = r_free_cnt + CNT_W'(1);
                            end
                            n_state = S_LRD;
                        end
                    end
                    default: begin
                        n_res.status = STS_COUNT_ERR;
                    end
                endcase
            end
            S_MISS: begin
                priority if (r_free_cnt != '0) begin
                    n_free_cnt = r_free_cnt - CNT_W'(1);
                    n_sidx     = n_free_cnt[IDX_W-1:0];
                    stk_raddr  = n_free_cnt[IDX_W-1:0];
                    n_state    = S_POP;
                end else if (r_qcnt != '0) begin
                    n_e     = r_head;
                    n_fill  = 1'b1;
                    n_state = S_LRD;
                end else begin
                    n_res.status    = STS_BYPASS;
                    n_res.need_open = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_POP: begin
                // A stack entry never written is taken to hold its own index.
                n_e     = r_stk_wr[r_sidx] ? r_stk_rd : r_sidx;
                n_state = S_FILL;
            end
            S_LRD: begin
                key_raddr = r_e;
                n_state   = S_UNLINK;
            end
            S_UNLINK: begin
                if (r_qcnt <= CNT_W'(1)) begin
                    n_qcnt = '0;
                end else begin
                    if (r_e == r_head) begin
                        n_head = r_next_rd;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = r_prev_rd;
                        next_wdata = r_next_rd;
                    end
                    if (r_e == r_tail) begin
                        n_tail = r_prev_rd;
                    end else begin
                        prev_we    = 1'b1;
                        prev_waddr = r_next_rd;
                        prev_wdata = r_prev_rd;
                    end
                    n_qcnt = r_qcnt - CNT_W'(1);
                end
                if (r_fill) begin
                    n_res.need_close       = 1'b1;
                    n_res.close_collection = r_key_rd.coll;
                    n_res.close_handle     = r_key_rd.handle;
                    n_res.close_kind       = r_key_rd.okind;
                    n_state                = S_FILL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FILL: begin
                key_we          = 1'b1;
                meta_we         = 1'b1;
                n_live[r_e]     = 1'b1;
                n_res.slot      = r_e;
                n_res.need_open = 1'b1;
                n_res.status    = r_fill ? STS_FILL_EVICT : STS_FILL_FREE;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_live      <= '0;
            r_stk_wr    <= '0;
            r_free_cnt  <= CNT_W'(ENTRIES);
            r_qcnt      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_live      <= n_live;
            r_stk_wr    <= n_stk_wr;
            r_free_cnt  <= n_free_cnt;
            r_qcnt      <= n_qcnt;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
        end
        r_req   <= n_req;
        r_pidx  <= n_pidx;
        r_e     <= n_e;
        r_sidx  <= n_sidx;
        r_fill  <= n_fill;
        r_close <= n_close;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Between requests every entry is either on the free stack or live.
    `RLHC_ASSERT(a_live_vs_free, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> ($countones(r_live) == (ENTRIES - int'(r_free_cnt))))
    // The unused queue only holds live entries.
    `RLHC_ASSERT(a_queue_bound, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> (int'(r_qcnt) <= $countones(r_live)))
    `RLHC_ASSERT(a_free_bound, i_clk, i_rst_n,
        r_free_cnt <= CNT_W'(ENTRIES))

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Handle cache regression
// Drives get, put and remove words into the handle cache. A behavioural copy
// of the table, free stack and unused queue predicts every result word, and
// each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import rlhc_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int ST_FREE   = 0;
    localparam int ST_USED   = 1;
    localparam int ST_UNUSED = 2;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    refcounted_lru_handle_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // Shadow of the cache contents.
    logic signed [31:0]  tab_coll   [ENTRIES];
    logic [63:0]         tab_handle [ENTRIES];
    logic [REF_BITS-1:0] tab_refs   [ENTRIES];
    int                  tab_state  [ENTRIES];
    logic [1:0]          tab_kind   [ENTRIES];
    int                  free_stk   [$];
    int                  lru_order  [$];

    t_out expected_words [$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_recv;
    int   hold_cycles;
    longint cycles;

    // Keys that the random traffic draws from, so that hits and removes occur.
    logic signed [31:0] pool_coll   [96];
    logic [63:0]        pool_handle [96];
    // Slots currently held by software, for well-formed puts.
    int held_slots [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int find_entry(logic signed [31:0] c, logic [63:0] h);
        for (int i = 0; i < ENTRIES; i++)
            if (tab_state[i] != ST_FREE && tab_coll[i] == c && tab_handle[i] == h)
                return i;
        return -1;
    endfunction

    function automatic void drop_from_lru(int e);
        for (int i = 0; i < lru_order.size(); i++)
            if (lru_order[i] == e) begin
                lru_order.delete(i);
                return;
            end
    endfunction

    function automatic t_out cache_predict(t_in w);
        t_out r;
        int e;
        r = '0;
        case (w.command)
            CMD_GET: begin
                e = find_entry(w.key_collection, w.key_handle);
                if (e >= 0) begin
                    r.slot = e[5:0];
                    if (tab_refs[e] == {REF_BITS{1'b1}}) begin
                        r.status = STS_COUNT_ERR;
                        return r;
                    end
                    if (tab_state[e] == ST_UNUSED) begin
                        drop_from_lru(e);
                        tab_state[e] = ST_USED;
                    end
                    tab_refs[e]++;
                    r.status = STS_HIT;
                    return r;
                end
                if (free_stk.size() > 0) begin
                    e = free_stk.pop_back();
                    r.status = STS_FILL_FREE;
                end else if (lru_order.size() > 0) begin
                    e = lru_order.pop_front();
                    r.need_close = 1'b1;
                    r.close_collection = tab_coll[e];
                    r.close_handle = tab_handle[e];
                    r.close_kind = tab_kind[e];
                    r.status = STS_FILL_EVICT;
                end else begin
                    r.status = STS_BYPASS;
                    r.need_open = 1'b1;
                    return r;
                end
                tab_refs[e] = REF_BITS'(1);
                tab_coll[e] = w.key_collection;
                tab_handle[e] = w.key_handle;
                tab_kind[e] = w.open_kind;
                tab_state[e] = ST_USED;
                r.slot = e[5:0];
                r.need_open = 1'b1;
            end
            CMD_PUT: begin
                if (!w.ref_cached) begin
                    r.status = STS_PUT_UNCACHE;
                    r.need_close = 1'b1;
                    return r;
                end
                r.slot = w.ref_slot;
                e = int'(w.ref_slot);
                if (tab_state[e] != ST_USED || tab_refs[e] == '0) begin
                    r.status = STS_COUNT_ERR;
                    return r;
                end
                tab_refs[e]--;
                if (tab_refs[e] == '0) begin
                    tab_state[e] = ST_UNUSED;
                    lru_order.push_back(e);
                    r.status = STS_PUT_RELEASE;
                end else begin
                    r.status = STS_PUT_KEPT;
                end
            end
            CMD_REMOVE: begin
                e = find_entry(w.key_collection, w.key_handle);
                if (e < 0) begin
                    r.status = STS_NOT_CACHED;
                    return r;
                end
                r.slot = e[5:0];
                if (tab_state[e] != ST_UNUSED) begin
                    r.status = STS_IN_USE;
                    return r;
                end
                drop_from_lru(e);
                r.need_close = 1'b1;
                r.close_collection = tab_coll[e];
                r.close_handle = tab_handle[e];
                r.close_kind = tab_kind[e];
                tab_state[e] = ST_FREE;
                tab_refs[e] = '0;
                free_stk.push_back(e);
                r.status = STS_REMOVED;
            end
            default: r.status = STS_COUNT_ERR;
        endcase
        return r;
    endfunction

    // Sends one word; the prediction is made at the accepting edge.
    task automatic send_word(t_in w);
        t_out r;
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        i_in <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = cache_predict(w);
        expected_words.push_back(r);
        if (w.command == CMD_GET && r.status <= STS_FILL_EVICT)
            held_slots.push_back(int'(r.slot));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Receiver stall pattern and long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_recv) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            i_out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out x;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("refcounted_lru_handle_cache regression: fail");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                errors++;
            end else begin
                x = expected_words.pop_front();
                if (x.status !== o_out.status || x.slot !== o_out.slot ||
                    x.need_open !== o_out.need_open ||
                    x.need_close !== o_out.need_close ||
                    x.close_collection !== o_out.close_collection ||
                    x.close_handle !== o_out.close_handle ||
                    x.close_kind !== o_out.close_kind) begin
                    $display("%0t: mismatch expected %h actual %h", $time, x, o_out);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (expected_words.size() > 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic t_in make_get(int k, logic [1:0] kind);
        t_in w;
        w = '0;
        w.command = CMD_GET;
        w.key_collection = pool_coll[k];
        w.key_handle = pool_handle[k];
        w.open_kind = kind;
        return w;
    endfunction

    function automatic t_in make_put(bit cached, logic [5:0] s);
        t_in w;
        w = '0;
        w.command = CMD_PUT;
        w.ref_cached = cached;
        w.ref_slot = s;
        w.key_collection = $urandom;
        w.open_kind = 2'($urandom);
        return w;
    endfunction

    task automatic put_held();
        int i;
        i = $urandom_range(held_slots.size() - 1);
        send_word(make_put(1'b1, 6'(held_slots[i])));
        held_slots.delete(i);
    endtask

    // Extremes of the keys, every command, the unknown command and count errors.
    task automatic test_directed();
        t_in w;
        w = make_get(0, 2'd3);
        send_word(w);
        send_word(w);
        w = make_get(1, 2'd0);
        send_word(w);
        w.command = CMD_REMOVE;
        send_word(w);
        send_word(make_put(1'b1, 6'(held_slots[held_slots.size() - 1])));
        held_slots.delete(held_slots.size() - 1);
        send_word(w);
        send_word(w);
        send_word(make_put(1'b0, 6'd63));
        send_word(make_put(1'b1, 6'd40));
        w = '1;
        send_word(w);
        w.command = CMD_GET;
        send_word(w);
        send_word(make_put(1'b1, 6'(held_slots.pop_back())));
        send_word(make_get(0, 2'd1));
        send_word(make_put(1'b1, 6'(held_slots.pop_back())));
        send_word(make_put(1'b1, 6'(held_slots.pop_back())));
        send_word(make_put(1'b1, 6'(held_slots.pop_back())));
        send_word(make_get(0, 2'd2));
        drain();
    endtask

    // Fill the table past its size to force bypasses, then release and re-get to
    // force evictions.
    task automatic test_eviction();
        for (int i = 0; i < 70; i++) send_word(make_get(i + 2, i[1:0]));
        for (int i = 0; i < 30; i++) put_held();
        for (int i = 0; i < 40; i++) send_word(make_get(72 + i % 24, 2'd1));
        while (held_slots.size() > 0) put_held();
        drain();
    endtask

    task automatic test_random(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(99);
            if (c < 45)
                send_word(make_get($urandom_range(95), 2'($urandom)));
            else if (c < 80 && held_slots.size() > 0)
                put_held();
            else if (c < 92) begin
                t_in w;
                w = make_get($urandom_range(95), 2'($urandom));
                w.command = CMD_REMOVE;
                send_word(w);
            end else if (c < 96)
                send_word(make_put(1'($urandom_range(1)), 6'($urandom)));
            else begin
                t_in w;
                w = '0;
                w.command = CMD_GET;
                w.key_collection = $urandom;
                w.key_handle = {$urandom, $urandom};
                w.open_kind = 2'($urandom);
                send_word(w);
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        hold_cycles = 0;
        hold_recv = 1'b1;
        fork
            test_random(12);
            begin
                while (hold_cycles < 600) @(negedge i_clk);
                hold_recv = 1'b0;
            end
        join
        drain();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            tab_state[i] = ST_FREE;
            tab_refs[i] = '0;
            tab_coll[i] = '0;
            tab_handle[i] = '0;
            tab_kind[i] = '0;
            free_stk.push_back(i);
        end
        pool_coll[0] = 32'sh7fffffff;
        pool_handle[0] = 64'hffff_ffff_ffff_ffff;
        pool_coll[1] = 32'sh80000000;
        pool_handle[1] = '0;
        for (int i = 2; i < 96; i++) begin
            pool_coll[i] = (i % 3 == 0) ? $urandom : $urandom_range(3);
            pool_handle[i] = (i % 2 == 0) ? {$urandom, $urandom} : 64'(i);
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        send_idle_pct = 38;
        recv_idle_pct = 49;
        test_eviction();
        test_random(600);
        drain();
        test_backpressure();
        send_idle_pct = 49;
        recv_idle_pct = 38;
        test_random(600);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        drain();

        if (errors == 0)
            $display("refcounted_lru_handle_cache regression: pass");
        else
            $display("refcounted_lru_handle_cache regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/rlhc_pkg.sv
src/refcounted_lru_handle_cache.sv
tb/sv/testbench.sv
